@@ rtl/jcse_pkg.sv @@
// jcse_pkg: shared types and constants for the jpeg comment segment extractor
// used by jcse_front, jcse_fifo, jcse_back and the top level; no dependencies
package jcse_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] BYTE_FF  = 8'hFF;
	localparam logic [7:0] MARK_SOI = 8'hD8;
	localparam logic [7:0] MARK_EOI = 8'hD9;
	localparam logic [7:0] MARK_SOS = 8'hDA;
	localparam logic [7:0] MARK_COM = 8'hFE;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [15:0] MIN_LEN = 16'd2;

	typedef enum logic [6:0] {
		PH_SOI_FF    = 7'b0000001,
		PH_SOI_D8    = 7'b0000010,
		PH_MARK_FF   = 7'b0000100,
		PH_MARK_CODE = 7'b0001000,
		PH_LEN_HI    = 7'b0010000,
		PH_LEN_LO    = 7'b0100000,
		PH_PAYLOAD   = 7'b1000000
	} phase_t;

	typedef enum logic [2:0] {
		ST_COMMENT = 3'd0,
		ST_DONE    = 3'd1,
		ST_TRUNC   = 3'd2,
		ST_NOTJPEG = 3'd3,
		ST_BADSOI  = 3'd4,
		ST_SHORT   = 3'd5
	} status_t;

	// one queued action: one result, or a comment byte plus its newline
	typedef struct packed {
		logic       two;
		status_t    status;
		logic [7:0] data;
	} act_t;

endpackage

@@ rtl/jcse_front.sv @@
// jcse_front: per-byte marker segment parser, decides for each byte whether it queues an action
// depends on jcse_pkg
module jcse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              sof,
	input  logic              eof,
	input  logic [7:0]        data_byte,
	input  logic              fifo_full,
	output logic              push,
	output jcse_pkg::act_t    act
);

	jcse_pkg::phase_t phase_q, ph, phase_d;
	logic             fin_q, fin, fin_d;
	logic             com_q, com, com_d;
	logic [7:0]       len_hi_q, len_hi_d;
	logic [15:0]      rem_q, rem_d;
	logic [15:0]      len;
	logic             push_c;
	logic             accept;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && push_c;
	assign len      = {len_hi_q, data_byte};

	always_comb begin
		ph       = sof ? jcse_pkg::PH_SOI_FF : phase_q;
		fin      = sof ? 1'b0 : fin_q;
		com      = sof ? 1'b0 : com_q;
		phase_d  = ph;
		fin_d    = fin;
		com_d    = com;
		len_hi_d = len_hi_q;
		rem_d    = sof ? '0 : rem_q;
		push_c   = 1'b0;
		act      = '{two: 1'b0, status: jcse_pkg::ST_COMMENT, data: 8'h00};
		if (!fin) begin
			if (eof) begin
				push_c     = 1'b1;
				act.status = jcse_pkg::ST_TRUNC;
				fin_d      = 1'b1;
			end else begin
				case (ph)
					jcse_pkg::PH_SOI_FF: begin
						if (data_byte != jcse_pkg::BYTE_FF) begin
							push_c     = 1'b1;
							act.status = jcse_pkg::ST_NOTJPEG;
							fin_d      = 1'b1;
						end else begin
							phase_d = jcse_pkg::PH_SOI_D8;
						end
					end
					jcse_pkg::PH_SOI_D8: begin
						if (data_byte != jcse_pkg::MARK_SOI) begin
							push_c     = 1'b1;
							act.status = jcse_pkg::ST_NOTJPEG;
							fin_d      = 1'b1;
						end else begin
							phase_d = jcse_pkg::PH_MARK_FF;
						end
					end
					jcse_pkg::PH_MARK_FF: begin
						if (data_byte != jcse_pkg::BYTE_FF) begin
							push_c     = 1'b1;
							act.status = jcse_pkg::ST_NOTJPEG;
							fin_d      = 1'b1;
						end else begin
							phase_d = jcse_pkg::PH_MARK_CODE;
						end
					end
					jcse_pkg::PH_MARK_CODE: begin
						if (data_byte == jcse_pkg::BYTE_FF) begin
							phase_d = jcse_pkg::PH_MARK_CODE;
						end else if (data_byte == jcse_pkg::MARK_SOI) begin
							push_c     = 1'b1;
							act.status = jcse_pkg::ST_BADSOI;
							fin_d      = 1'b1;
						end else if (data_byte == jcse_pkg::MARK_EOI ||
								data_byte == jcse_pkg::MARK_SOS) begin
							push_c     = 1'b1;
							act.status = jcse_pkg::ST_DONE;
							fin_d      = 1'b1;
						end else begin
							com_d   = (data_byte == jcse_pkg::MARK_COM);
							phase_d = jcse_pkg::PH_LEN_HI;
						end
					end
					jcse_pkg::PH_LEN_HI: begin
						len_hi_d = data_byte;
						phase_d  = jcse_pkg::PH_LEN_LO;
					end
					jcse_pkg::PH_LEN_LO: begin
						if (len < jcse_pkg::MIN_LEN) begin
							push_c     = 1'b1;
							act.status = jcse_pkg::ST_SHORT;
							fin_d      = 1'b1;
						end else begin
							rem_d = len - jcse_pkg::MIN_LEN;
							if (len == jcse_pkg::MIN_LEN) begin
								// empty comment: newline only
								push_c   = com;
								act.data = jcse_pkg::BYTE_LF;
								phase_d  = jcse_pkg::PH_MARK_FF;
							end else begin
								phase_d = jcse_pkg::PH_PAYLOAD;
							end
						end
					end
					jcse_pkg::PH_PAYLOAD: begin
						rem_d    = rem_q - 16'd1;
						push_c   = com;
						act.data = data_byte;
						if (rem_q == 16'd1) begin
							act.two = 1'b1;
							phase_d = jcse_pkg::PH_MARK_FF;
						end
					end
					default: begin
						push_c     = 1'b1;
						act.status = jcse_pkg::ST_NOTJPEG;
						fin_d      = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jcse_pkg::PH_SOI_FF;
			fin_q   <= 1'b1;
			com_q   <= 1'b0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			fin_q   <= fin_d;
			com_q   <= com_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_hi_q <= len_hi_d;
		end
	end

endmodule

@@ rtl/jcse_fifo.sv @@
// jcse_fifo: short action queue between the parser and the output stage
// depends on jcse_pkg
module jcse_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jcse_pkg::act_t    push_act,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output jcse_pkg::act_t    head
);

	jcse_pkg::act_t                  mem [jcse_pkg::FIFO_DEPTH];
	logic [jcse_pkg::PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [jcse_pkg::CNT_W-1:0]      count_q;

	assign full      = (count_q == jcse_pkg::CNT_W'(jcse_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/jcse_back.sv @@
// jcse_back: output register that expands queued actions into result words
// depends on jcse_pkg
module jcse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              act_valid,
	input  jcse_pkg::act_t    act,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_data,
	output logic [2:0]        out_status,
	output logic              out_last
);

	logic              valid_q;
	logic              nl_q;
	logic [7:0]        data_q;
	jcse_pkg::status_t status_q;
	logic              last_q;
	logic              load_ok;

	assign load_ok    = !valid_q || out_ready;
	assign pop        = load_ok && !nl_q && act_valid;
	assign out_valid  = valid_q;
	assign out_data   = data_q;
	assign out_status = status_q;
	assign out_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			nl_q    <= 1'b0;
		end else if (load_ok) begin
			if (nl_q) begin
				valid_q <= 1'b1;
				nl_q    <= 1'b0;
			end else begin
				valid_q <= act_valid;
				nl_q    <= act_valid && act.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (nl_q) begin
				data_q   <= jcse_pkg::BYTE_LF;
				status_q <= jcse_pkg::ST_COMMENT;
				last_q   <= 1'b1;
			end else if (act_valid) begin
				data_q   <= act.data;
				status_q <= act.status;
				last_q   <= !act.two;
			end
		end
	end

	// pending newline always sits behind a comment byte that is not last
	assert property (@(posedge clk) disable iff (!arst_n)
		nl_q |-> (valid_q && !last_q && status_q == jcse_pkg::ST_COMMENT))
		else $error("pending newline without comment byte in output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !nl_q)
		else $error("queue popped while newline pending");

	// terminal results carry a zero byte and close the item
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && status_q != jcse_pkg::ST_COMMENT) |-> (data_q == 8'h00 && last_q))
		else $error("terminal result with nonzero byte or not last");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> ($stable(data_q) && $stable(last_q)))
		else $error("output word changed while stalled");

endmodule

@@ rtl/jpeg_comment_segment_extractor.sv @@
// jpeg_comment_segment_extractor: top level, comment bytes out, one byte in per cycle
// while the action queue is not full; m_tvalid is driven by the output register
// throughput: one byte per cycle unless the queue is full; a comment's last byte
// gives a byte word and a newline word, absorbed by a four-entry action queue
// reset: parser idle until start_of_file, queue and output register empty
module jpeg_comment_segment_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [1:0]  s_tuser,  // [0] start_of_file, [1] end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] comment_byte
	output logic [2:0]  m_tuser,  // [2:0] status
	output logic        m_tlast
);

	logic           push, full, pop, not_empty;
	jcse_pkg::act_t push_act, head;

	jcse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.sof       (s_tuser[0]),
		.eof       (s_tuser[1]),
		.data_byte (s_tdata),
		.fifo_full (full),
		.push      (push),
		.act       (push_act)
	);

	jcse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_act  (push_act),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	jcse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.act_valid  (not_empty),
		.act        (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

@@ tb/jpeg_comment_segment_extractor_tb.sv @@
// jpeg_comment_segment_extractor_tb: self-checking bench for the jpeg comment extractor
// drives byte words through the input stream, predicts comment bytes and end statuses,
// compares them with the output stream; depends on jcse_pkg and the top level only
module jpeg_comment_segment_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_WORDS = 900;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = 16;
	localparam int unsigned N_DIRECTED   = 28;

	typedef struct packed {
		logic       sof;
		logic       eof;
		logic [7:0] data;
	} word_t;

	typedef struct packed {
		jcse_pkg::status_t status;
		logic [7:0]        chr;
		logic              last;
	} result_t;

	typedef enum logic [1:0] {
		EXP_MODEL,
		EXP_NONE,
		EXP_TERM
	} check_kind_t;

	typedef struct packed {
		word_t             w;
		check_kind_t       kind;
		jcse_pkg::status_t term_st;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;  // [7:0] data_byte
	logic [1:0] s_tuser;  // [0] start_of_file, [1] end_of_file
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;  // [7:0] comment_byte
	logic [2:0] m_tuser;  // [2:0] status
	logic       m_tlast;

	jpeg_comment_segment_extractor u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// parser shadow state
	jcse_pkg::phase_t cur_phase   = jcse_pkg::PH_SOI_FF;
	logic [7:0]       seg_marker  = 8'h00;
	logic [15:0]      seg_left    = 16'h0000;
	logic             parser_idle = 1'b1;
	logic             step_active;

	result_t step_results[$];
	result_t expected_results[$];
	word_t   file_words[$];

	int unsigned burst_left      = 0;
	int unsigned errors          = 0;
	int unsigned words_parsed    = 0;
	int unsigned files_sent      = 0;
	int unsigned comment_checked = 0;
	int unsigned status_checked  = 0;
	int unsigned idle_cycles     = 0;

	row_t dir_rows [0:N_DIRECTED-1] = '{
		'{'{1'b0, 1'b0, 8'hFF}, EXP_NONE,  jcse_pkg::ST_COMMENT},
		'{'{1'b1, 1'b1, 8'h00}, EXP_TERM,  jcse_pkg::ST_TRUNC},
		'{'{1'b1, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hD8}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFE}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'h00}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'h02}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFE}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'h00}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'h03}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'h41}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hD9}, EXP_TERM,  jcse_pkg::ST_DONE},
		'{'{1'b1, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hD8}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hD8}, EXP_TERM,  jcse_pkg::ST_BADSOI},
		'{'{1'b1, 1'b0, 8'h00}, EXP_TERM,  jcse_pkg::ST_NOTJPEG},
		'{'{1'b1, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hD8}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hFF}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'hC0}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'h00}, EXP_MODEL, jcse_pkg::ST_COMMENT},
		'{'{1'b0, 1'b0, 8'h01}, EXP_TERM,  jcse_pkg::ST_SHORT},
		'{'{1'b0, 1'b1, 8'h00}, EXP_NONE,  jcse_pkg::ST_COMMENT}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// append one predicted result of the current step
	task automatic add_result(input jcse_pkg::status_t st, input logic [7:0] chr);
		result_t r;
		begin
			r.status = st;
			r.chr    = chr;
			r.last   = 1'b0;
			step_results.insert(step_results.size(), r);
		end
	endtask

	// append one word to the file being built
	task automatic add_word(input logic sof, input logic eof, input logic [7:0] data);
		word_t fw;
		begin
			fw.sof  = sof;
			fw.eof  = eof;
			fw.data = data;
			file_words.insert(file_words.size(), fw);
		end
	endtask

	// one parser step per accepted word, results land in step_results
	task automatic parse_word(input word_t w);
		logic [15:0] seg_len;
		begin
			step_results.delete();
			if (w.sof) begin
				cur_phase   = jcse_pkg::PH_SOI_FF;
				seg_marker  = 8'h00;
				seg_left    = 16'h0000;
				parser_idle = 1'b0;
			end
			step_active = !parser_idle;
			if (!parser_idle) begin
				if (w.eof) begin
					add_result(jcse_pkg::ST_TRUNC, 8'h00);
				end else begin
					case (cur_phase)
						jcse_pkg::PH_SOI_FF: begin
							if (w.data != jcse_pkg::BYTE_FF)
								add_result(jcse_pkg::ST_NOTJPEG, 8'h00);
							else cur_phase = jcse_pkg::PH_SOI_D8;
						end
						jcse_pkg::PH_SOI_D8: begin
							if (w.data != jcse_pkg::MARK_SOI)
								add_result(jcse_pkg::ST_NOTJPEG, 8'h00);
							else cur_phase = jcse_pkg::PH_MARK_FF;
						end
						jcse_pkg::PH_MARK_FF: begin
							if (w.data != jcse_pkg::BYTE_FF)
								add_result(jcse_pkg::ST_NOTJPEG, 8'h00);
							else cur_phase = jcse_pkg::PH_MARK_CODE;
						end
						jcse_pkg::PH_MARK_CODE: begin
							if (w.data == jcse_pkg::BYTE_FF) begin
								cur_phase = jcse_pkg::PH_MARK_CODE;
							end else if (w.data == jcse_pkg::MARK_SOI) begin
								add_result(jcse_pkg::ST_BADSOI, 8'h00);
							end else if (w.data == jcse_pkg::MARK_EOI ||
									w.data == jcse_pkg::MARK_SOS) begin
								add_result(jcse_pkg::ST_DONE, 8'h00);
							end else begin
								seg_marker = w.data;
								cur_phase  = jcse_pkg::PH_LEN_HI;
							end
						end
						jcse_pkg::PH_LEN_HI: begin
							seg_left  = {w.data, 8'h00};
							cur_phase = jcse_pkg::PH_LEN_LO;
						end
						jcse_pkg::PH_LEN_LO: begin
							seg_len = seg_left | {8'h00, w.data};
							if (seg_len < jcse_pkg::MIN_LEN) begin
								add_result(jcse_pkg::ST_SHORT, 8'h00);
							end else begin
								seg_left = seg_len - jcse_pkg::MIN_LEN;
								if (seg_left == 16'h0000) begin
									if (seg_marker == jcse_pkg::MARK_COM)
										add_result(jcse_pkg::ST_COMMENT, jcse_pkg::BYTE_LF);
									cur_phase = jcse_pkg::PH_MARK_FF;
								end else begin
									cur_phase = jcse_pkg::PH_PAYLOAD;
								end
							end
						end
						jcse_pkg::PH_PAYLOAD: begin
							seg_left = seg_left - 16'd1;
							if (seg_marker == jcse_pkg::MARK_COM)
								add_result(jcse_pkg::ST_COMMENT, w.data);
							if (seg_left == 16'h0000) begin
								if (seg_marker == jcse_pkg::MARK_COM)
									add_result(jcse_pkg::ST_COMMENT, jcse_pkg::BYTE_LF);
								cur_phase = jcse_pkg::PH_MARK_FF;
							end
						end
						default: add_result(jcse_pkg::ST_NOTJPEG, 8'h00);
					endcase
				end
				if (step_results.size() > 0) begin
					if (step_results[$].status != jcse_pkg::ST_COMMENT) parser_idle = 1'b1;
					step_results[$].last = 1'b1;
				end
			end
		end
	endtask

	// offer one word in bursts with random gaps, then record what it should cause
	task automatic send_word(input word_t w, input check_kind_t kind,
			input jcse_pkg::status_t term_st);
		result_t term_res;
		begin
			if (burst_left == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
			end
			burst_left--;
			s_tvalid <= 1'b1;
			s_tdata  <= w.data;
			s_tuser  <= {w.eof, w.sof};
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			parse_word(w);
			case (kind)
				EXP_MODEL: begin
					foreach (step_results[i])
						expected_results.insert(expected_results.size(), step_results[i]);
				end
				EXP_TERM: begin
					term_res.status = term_st;
					term_res.chr    = 8'h00;
					term_res.last   = 1'b1;
					expected_results.insert(expected_results.size(), term_res);
				end
				default: ;
			endcase
		end
	endtask

	initial begin
		int unsigned n_seg;
		int unsigned seg_len;
		int unsigned pick;
		int unsigned cut;
		logic [7:0]  mark;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = 2'b00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_word(dir_rows[i].w, dir_rows[i].kind, dir_rows[i].term_st);

		while (words_parsed < RANDOM_WORDS) begin
			file_words.delete();
			if ($urandom_range(0, 19) == 0) begin
				add_word(1'b1, 1'b1, 8'($urandom));
			end else begin
				add_word(1'b1, 1'b0, jcse_pkg::BYTE_FF);
				add_word(1'b0, 1'b0, jcse_pkg::MARK_SOI);
				n_seg = $urandom_range(0, 4);
				for (int s = 0; s < n_seg; s++) begin
					add_word(1'b0, 1'b0, jcse_pkg::BYTE_FF);
					if ($urandom_range(0, 6) == 0)
						repeat ($urandom_range(1, 3)) add_word(1'b0, 1'b0, jcse_pkg::BYTE_FF);
					if ($urandom_range(0, 1) == 0) begin
						mark = jcse_pkg::MARK_COM;
					end else begin
						do mark = 8'($urandom);
						while (mark == jcse_pkg::BYTE_FF || mark == jcse_pkg::MARK_SOI ||
							mark == jcse_pkg::MARK_EOI || mark == jcse_pkg::MARK_SOS);
					end
					add_word(1'b0, 1'b0, mark);
					seg_len = ($urandom_range(0, 59) == 0) ? $urandom_range(256, 300)
						: $urandom_range(2, 12);
					add_word(1'b0, 1'b0, 8'(seg_len >> 8));
					add_word(1'b0, 1'b0, 8'(seg_len));
					repeat (seg_len - 2) add_word(1'b0, 1'b0, 8'($urandom));
				end
				pick = $urandom_range(0, 9);
				if (pick <= 7) add_word(1'b0, 1'b0, jcse_pkg::BYTE_FF);
				case (pick)
					0, 1, 2, 3: add_word(1'b0, 1'b0, jcse_pkg::MARK_EOI);
					4, 5:       add_word(1'b0, 1'b0, jcse_pkg::MARK_SOS);
					6:          add_word(1'b0, 1'b0, jcse_pkg::MARK_SOI);
					7: begin
						add_word(1'b0, 1'b0, 8'hC4);
						add_word(1'b0, 1'b0, 8'h00);
						add_word(1'b0, 1'b0, 8'($urandom_range(0, 1)));
					end
					8:          ;
					default:    add_word(1'b0, 1'b1, 8'($urandom));
				endcase
				// broken files: a flipped byte or an early end
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					cut = $urandom_range(0, file_words.size() - 1);
					file_words[cut].data = 8'($urandom);
				end else if (pick == 1) begin
					cut = $urandom_range(1, file_words.size() - 1);
					file_words = file_words[0:cut-1];
					add_word(1'b0, 1'b1, 8'($urandom));
				end
			end
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3))
					add_word(1'b0, 1'($urandom), 8'($urandom));
			files_sent++;
			foreach (file_words[i]) begin
				send_word(file_words[i], EXP_MODEL, jcse_pkg::ST_COMMENT);
				if (step_active) words_parsed++;
			end
		end
		s_tvalid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d random files, %0d parsed words after the directed table",
			files_sent, words_parsed);
		$display("checked %0d comment words and %0d end statuses", comment_checked,
			status_checked);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// receiver stall pattern, changes mode every so often
	int unsigned rx_cnt  = 0;
	int unsigned rx_mode = 0;
	always @(posedge clk) begin
		rx_cnt <= rx_cnt + 1;
		if (rx_cnt % 128 == 127) rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom);
			2:       m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((rx_cnt % 8) < 5);
		endcase
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected word: status %0d data %h last %b", $time, m_tuser,
					m_tdata, m_tlast);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (want.status == jcse_pkg::ST_COMMENT) comment_checked++;
				else status_checked++;
				if (m_tuser !== want.status) begin
					$display("%0t status mismatch: expected %0d actual %0d", $time,
						want.status, m_tuser);
					errors++;
				end
				if (m_tdata !== want.chr) begin
					$display("%0t comment byte mismatch: expected %h actual %h", $time,
						want.chr, m_tdata);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t last mismatch: expected %b actual %b", $time, want.last,
						m_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t no progress for %0d cycles, %0d words still expected", $time,
					idle_cycles, expected_results.size());
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
